// ----- rtl/tdpl_pkg.sv -----
// ----------------------------------------------------------------------------
// tdpl_pkg
// Shared widths, register map and state codes of the trial division prime
// lister.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpl_pkg;

  localparam int VALUE_BITS = 8;
  localparam int CAND_W     = VALUE_BITS + 1;
  localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int COUNT_W    = 16;
  localparam int METHOD_W   = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_METHOD = CFG_ADDR_W'(0);

  // method register bits
  localparam int METHOD_ODD_BIT  = 0;
  localparam int METHOD_ROOT_BIT = 1;

  localparam logic [COUNT_W-1:0]   COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [CAND_W-1:0]    FIRST_EVEN  = CAND_W'(2);
  localparam logic [CAND_W-1:0]    FIRST_ODD   = CAND_W'(3);
  localparam logic [VALUE_BITS-1:0] PRIME_TWO  = VALUE_BITS'(2);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_TWO  = 8'b0000_0010,
    ST_CAND = 8'b0000_0100,
    ST_ROOT = 8'b0000_1000,
    ST_DCHK = 8'b0001_0000,
    ST_MOD  = 8'b0010_0000,
    ST_EMIT = 8'b0100_0000,
    ST_CNT  = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/tdpl_if.sv -----
// ----------------------------------------------------------------------------
// tdpl_in_if / tdpl_out_if
// Valid/ready channels carrying the limit and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdpl_in_if
  import tdpl_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] limit;

  modport source (output valid, output limit, input ready);
  modport sink   (input valid, input limit, output ready);
endinterface

interface tdpl_out_if
  import tdpl_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] prime_value;
  logic                  is_count;
  logic [COUNT_W-1:0]    mod_count;
  logic                  last;

  modport source (output valid, output prime_value, output is_count,
                  output mod_count, output last, input ready);
  modport sink   (input valid, input prime_value, input is_count,
                  input mod_count, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/trial_division_prime_lister_top.sv -----
// Per limit, the run walks every candidate; each trial modulo passes the
//   check state and then the shared bit-serial remainder unit, and the root
//   method adds root steps per candidate.
// Throughput: one limit per run; in_chan.ready is high only in idle.
//   The shared remainder unit, one candidate bit at a time, sets the rate.
// Reset: synchronous active-low rst_n; returns to idle, method = 0.
// ----------------------------------------------------------------------------
// trial_division_prime_lister_top
// Lists every prime up to a limit by trial division, then a count item with
// the number of modulo operations. Method register selects the variant.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_lister_top
  import tdpl_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  tdpl_in_if.sink                in_chan,
  tdpl_out_if.source             out_chan,
  input  wire                    cfg_psel,
  input  wire                    cfg_penable,
  input  wire                    cfg_pwrite,
  input  wire [CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire [CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  // control
  state_t                  state_r, state_nxt;
  logic [METHOD_W-1:0]     method_r;
  logic                    odd_only, use_root;
  logic [CAND_W-1:0]       start_val, stride;

  // run state
  logic [VALUE_BITS-1:0]   lim_r, lim_nxt;
  logic [CAND_W-1:0]       cand_r, cand_nxt;
  logic [CAND_W-1:0]       div_r, div_nxt;
  logic [VALUE_BITS-1:0]   bound_r, bound_nxt;
  logic [VALUE_BITS-1:0]   root_r, root_nxt;     // running floor root
  logic [CAND_W-1:0]       nsq_r, nsq_nxt;       // (root_r + 1)^2
  logic [COUNT_W-1:0]      ops_r, ops_nxt;

  // shared remainder unit
  logic [VALUE_BITS-1:0]   rem_r, rem_nxt;
  logic [BIT_CNT_W-1:0]    bit_idx_r, bit_idx_nxt;
  logic [VALUE_BITS-1:0]   cand_lo;
  logic [CAND_W-1:0]       trial;
  logic [VALUE_BITS-1:0]   rem_step;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0]   out_prime_r, out_prime_nxt;
  logic                    out_is_count_r, out_is_count_nxt;
  logic [COUNT_W-1:0]      out_count_r, out_count_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    slot_free;

  logic                    in_xfer;
  logic                    cfg_wr;

  // --------------------------------------------------------------------------
  // Configuration port: one register, written on the access phase.
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == ADDR_METHOD) begin
      cfg_prdata = CFG_DATA_W'(method_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= '0;
    end else if (cfg_wr && cfg_paddr == ADDR_METHOD) begin
      method_r <= cfg_pwdata[METHOD_W-1:0];
    end
  end

  assign odd_only  = method_r[METHOD_ODD_BIT];
  assign use_root  = method_r[METHOD_ROOT_BIT];
  assign start_val = odd_only ? FIRST_ODD : FIRST_EVEN;
  assign stride    = odd_only ? CAND_W'(2) : CAND_W'(1);

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_valid_r || out_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.prime_value = out_prime_r;
  assign out_chan.is_count    = out_is_count_r;
  assign out_chan.mod_count   = out_count_r;
  assign out_chan.last        = out_last_r;

  // --------------------------------------------------------------------------
  // Bit-serial restoring remainder: one candidate bit per cycle, MSB first.
  // Partial remainder stays below the divisor, so VALUE_BITS bits suffice.
  // --------------------------------------------------------------------------
  assign cand_lo = cand_r[VALUE_BITS-1:0];
  assign trial   = {rem_r, cand_lo[bit_idx_r]};

  always_comb begin
    if (trial >= div_r) begin
      rem_step = VALUE_BITS'(trial - div_r);
    end else begin
      rem_step = trial[VALUE_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt        = state_r;
    lim_nxt          = lim_r;
    cand_nxt         = cand_r;
    div_nxt          = div_r;
    bound_nxt        = bound_r;
    root_nxt         = root_r;
    nsq_nxt          = nsq_r;
    ops_nxt          = ops_r;
    rem_nxt          = rem_r;
    bit_idx_nxt      = bit_idx_r;
    out_valid_nxt    = out_valid_r && !out_chan.ready;
    out_prime_nxt    = out_prime_r;
    out_is_count_nxt = out_is_count_r;
    out_count_nxt    = out_count_r;
    out_last_nxt     = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          lim_nxt  = in_chan.limit;
          cand_nxt = start_val;
          ops_nxt  = '0;
          root_nxt = '0;
          nsq_nxt  = CAND_W'(1);
          // odd-only methods hand out 2 without testing it
          if (odd_only && in_chan.limit >= PRIME_TWO) begin
            state_nxt = ST_TWO;
          end else begin
            state_nxt = ST_CAND;
          end
        end
      end

      ST_TWO: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_prime_nxt    = PRIME_TWO;
          out_is_count_nxt = 1'b0;
          out_count_nxt    = '0;
          out_last_nxt     = 1'b0;
          state_nxt        = ST_CAND;
        end
      end

      ST_CAND: begin
        if (cand_r > {1'b0, lim_r}) begin
          state_nxt = ST_CNT;
        end else if (use_root) begin
          state_nxt = ST_ROOT;
        end else begin
          bound_nxt = VALUE_BITS'(cand_r - CAND_W'(1));
          div_nxt   = start_val;
          state_nxt = ST_DCHK;
        end
      end

      // candidates rise, so the floor root only ever steps up
      ST_ROOT: begin
        if (nsq_r <= cand_r) begin
          root_nxt = root_r + VALUE_BITS'(1);
          nsq_nxt  = nsq_r + {root_r, 1'b0} + CAND_W'(3);
        end else begin
          bound_nxt = root_r;
          div_nxt   = start_val;
          state_nxt = ST_DCHK;
        end
      end

      ST_DCHK: begin
        if (div_r > {1'b0, bound_r}) begin
          state_nxt = ST_EMIT;
        end else begin
          if (ops_r != COUNT_MAX) begin
            ops_nxt = ops_r + COUNT_W'(1);
          end
          rem_nxt     = '0;
          bit_idx_nxt = BIT_CNT_W'(VALUE_BITS - 1);
          state_nxt   = ST_MOD;
        end
      end

      ST_MOD: begin
        rem_nxt = rem_step;
        if (bit_idx_r == '0) begin
          if (rem_step == '0) begin
            cand_nxt  = cand_r + stride;     // divisor found: composite
            state_nxt = ST_CAND;
          end else begin
            div_nxt   = div_r + stride;
            state_nxt = ST_DCHK;
          end
        end else begin
          bit_idx_nxt = bit_idx_r - BIT_CNT_W'(1);
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_prime_nxt    = cand_lo;
          out_is_count_nxt = 1'b0;
          out_count_nxt    = '0;
          out_last_nxt     = 1'b0;
          cand_nxt         = cand_r + stride;
          state_nxt        = ST_CAND;
        end
      end

      ST_CNT: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_prime_nxt    = '0;
          out_is_count_nxt = 1'b1;
          out_count_nxt    = ops_r;
          out_last_nxt     = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ops_r       <= '0;
      cand_r      <= '0;
      div_r       <= '0;
      bound_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ops_r       <= ops_nxt;
      cand_r      <= cand_nxt;
      div_r       <= div_nxt;
      bound_r     <= bound_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    lim_r          <= lim_nxt;
    root_r         <= root_nxt;
    nsq_r          <= nsq_nxt;
    rem_r          <= rem_nxt;
    bit_idx_r      <= bit_idx_nxt;
    out_prime_r    <= out_prime_nxt;
    out_is_count_r <= out_is_count_nxt;
    out_count_r    <= out_count_nxt;
    out_last_r     <= out_last_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/tdpl_checker.sv -----
// ----------------------------------------------------------------------------
// tdpl_checker
// Port-level checks of the prime lister, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpl_checker
  import tdpl_pkg::*;
(
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [VALUE_BITS-1:0] out_prime_value,
  input wire                  out_is_count,
  input wire [COUNT_W-1:0]    out_mod_count,
  input wire                  out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prime_value) &&
      $stable(out_is_count) && $stable(out_mod_count) && $stable(out_last))
    else $error("result changed while stalled");

  // one run at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  a_count_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_count |-> out_last && out_prime_value == '0)
    else $error("count item malformed");

  a_prime_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_count |->
      !out_last && out_mod_count == '0 && out_prime_value >= PRIME_TWO)
    else $error("prime item malformed");

endmodule

bind trial_division_prime_lister_top tdpl_checker u_tdpl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_prime_value (out_chan.prime_value),
  .out_is_count    (out_chan.is_count),
  .out_mod_count   (out_chan.mod_count),
  .out_last        (out_chan.last)
);

`default_nettype wire

// ----- dv/tb_trial_division_prime_lister_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trial_division_prime_lister_top
// Self-checking bench for the trial division prime lister. Limits go in on a
// valid/ready channel; each one yields the primes up to it and a closing
// count item. A local prime list builder predicts every item, and the
// monitor compares each result transfer with the oldest prediction. The
// method register is changed over APB between drained phases.
// ----------------------------------------------------------------------------

module tb_trial_division_prime_lister_top;
  import tdpl_pkg::*;

  // method codes, bit 0 = odd only, bit 1 = bounded by the floor root
  localparam logic [METHOD_W-1:0] METHOD_ALL      = METHOD_W'(0);
  localparam logic [METHOD_W-1:0] METHOD_ODD      = METHOD_W'(1);
  localparam logic [METHOD_W-1:0] METHOD_ROOT     = METHOD_W'(2);
  localparam logic [METHOD_W-1:0] METHOD_ODD_ROOT = METHOD_W'(3);

  localparam int MAX_GAP      = 80;   // longest idle stretch on either side
  localparam int TAIL_CYCLES  = 60;   // quiet time after the last result
  localparam int RAND_PHASES  = 5;
  localparam int RAND_PER_PH  = 15;

  typedef struct packed {
    logic [VALUE_BITS-1:0] prime_value;
    logic                  is_count;
    logic [COUNT_W-1:0]    mod_count;
    logic                  last;
  } lister_result_t;

  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tdpl_in_if  in_if ();
  tdpl_out_if out_if ();

  trial_division_prime_lister_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Bench state
  logic [VALUE_BITS-1:0] pending_limits[$];    // limits not yet transferred
  lister_result_t        expected_items[$];    // predicted result items
  logic [METHOD_W-1:0]   method_shadow;        // bench copy of the register
  int                    error_count;
  bit                    limit_taken;          // set at posedge, consumed at negedge
  bit                    quiet;                // no idling on either side
  int                    in_gap;
  int                    out_stall;
  longint                cycle_count;
  longint                cycle_allow;          // grows with each accepted limit

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Mostly zero, often a short gap, rarely a long stall.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, MAX_GAP);
  endfunction

  // Small limits dominate; the slow full-range ones are kept rare.
  function automatic logic [VALUE_BITS-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return VALUE_BITS'($urandom_range(0, 31));
    if (r < 85) return VALUE_BITS'($urandom_range(32, 90));
    if (r < 96) return VALUE_BITS'($urandom_range(91, 160));
    return VALUE_BITS'($urandom_range(161, (1 << VALUE_BITS) - 1));
  endfunction

  function automatic void push_result(input int value, input bit cnt_item,
                                      input int ops);
    lister_result_t r;
    r.prime_value = cnt_item ? '0 : VALUE_BITS'(value);
    r.is_count    = cnt_item;
    r.mod_count   = cnt_item ? COUNT_W'(ops) : '0;
    r.last        = cnt_item;
    expected_items.push_back(r);
  endfunction

  // Lists the primes up to lim as the chosen trial division variant finds
  // them, then the count item. Returns the number of items queued; the
  // modulo count goes to ops_out for the timeout allowance.
  function automatic int list_primes(input logic [VALUE_BITS-1:0] lim,
                                     input logic [METHOD_W-1:0] meth,
                                     output int ops_out);
    bit odd_only;
    bit use_root;
    bit prime;
    int start;
    int stride;
    int cand;
    int dvs;
    int bound;
    int ops;
    int n;
    odd_only = meth[METHOD_ODD_BIT];
    use_root = meth[METHOD_ROOT_BIT];
    start    = odd_only ? 3 : 2;
    stride   = odd_only ? 2 : 1;
    ops      = 0;
    n        = 0;
    // odd-only variants hand out 2 without a modulo, but only if it fits
    if (odd_only && lim >= 2) begin
      push_result(2, 1'b0, 0);
      n++;
    end
    for (cand = start; cand <= int'(lim); cand += stride) begin
      prime = 1'b1;
      if (use_root) begin
        bound = 0;
        while ((bound + 1) * (bound + 1) <= cand) bound++;
      end else begin
        bound = cand - 1;
      end
      for (dvs = start; dvs <= bound && prime; dvs += stride) begin
        if (ops < int'(COUNT_MAX)) ops++;   // saturating count
        if (cand % dvs == 0) prime = 1'b0;
      end
      if (prime) begin
        push_result(cand, 1'b0, 0);
        n++;
      end
    end
    push_result(0, 1'b1, ops);
    ops_out = ops;
    return n + 1;
  endfunction

  // APB write: setup cycle, then access cycle; the register takes the value
  // at the edge where psel, penable, pwrite and pready are all high.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_METHOD) method_shadow = data[METHOD_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // APB read with a compare against the bench copy of the register.
  task automatic cfg_read_check(input logic [CFG_ADDR_W-1:0] addr);
    logic [CFG_DATA_W-1:0] want;
    want = CFG_DATA_W'(method_shadow);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $error("method readback: expected %0d, got %0d", want, cfg_prdata);
      error_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Sender holds off until every predicted item has come back and the block
  // is idle again (ready only rises in idle).
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_limits.size() != 0 || expected_items.size() != 0 ||
           in_if.ready !== 1'b1);
  endtask

  task automatic set_method(input logic [METHOD_W-1:0] meth);
    wait_drained();
    cfg_write(ADDR_METHOD, CFG_DATA_W'(meth));
    cfg_read_check(ADDR_METHOD);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stim
    // directed limits per method: below two, the first primes, perfect
    // squares where the root bound is hit exactly, and the full range
    logic [VALUE_BITS-1:0] dir_all[5]      = '{VALUE_BITS'(0), VALUE_BITS'(1),
                                               VALUE_BITS'(2), VALUE_BITS'(3),
                                               VALUE_BITS'(255)};
    logic [VALUE_BITS-1:0] dir_odd[6]      = '{VALUE_BITS'(0), VALUE_BITS'(1),
                                               VALUE_BITS'(2), VALUE_BITS'(3),
                                               VALUE_BITS'(9), VALUE_BITS'(255)};
    logic [VALUE_BITS-1:0] dir_root[6]     = '{VALUE_BITS'(0), VALUE_BITS'(1),
                                               VALUE_BITS'(2), VALUE_BITS'(4),
                                               VALUE_BITS'(25), VALUE_BITS'(255)};
    logic [VALUE_BITS-1:0] dir_odd_root[7] = '{VALUE_BITS'(0), VALUE_BITS'(1),
                                               VALUE_BITS'(2), VALUE_BITS'(3),
                                               VALUE_BITS'(9), VALUE_BITS'(49),
                                               VALUE_BITS'(255)};
    int ph;
    int k;

    // every input known from time zero
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.limit   = '0;
    out_if.ready  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    method_shadow = METHOD_ALL;
    error_count   = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register comes out of reset as method 0
    cfg_read_check(ADDR_METHOD);

    // directed part, one phase per method
    set_method(METHOD_ALL);
    foreach (dir_all[i]) pending_limits.push_back(dir_all[i]);
    set_method(METHOD_ODD);
    foreach (dir_odd[i]) pending_limits.push_back(dir_odd[i]);
    set_method(METHOD_ROOT);
    foreach (dir_root[i]) pending_limits.push_back(dir_root[i]);
    set_method(METHOD_ODD_ROOT);
    foreach (dir_odd_root[i]) pending_limits.push_back(dir_odd_root[i]);

    // random part; each phase boundary also drains the block completely
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      set_method(METHOD_W'($urandom_range(0, 3)));
      for (k = 0; k < RAND_PER_PH; k++) pending_limits.push_back(pick_limit());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS trial_division_prime_lister_top");
    end else begin
      $display("FAIL trial_division_prime_lister_top");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input driver: presents the head of pending_limits at the falling edge,
  // holds it until the transfer, then idles a random gap.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : limit_driver
    logic next_valid;
    next_valid = 1'b0;
    if (rst_n) begin
      if (in_if.valid && !limit_taken) begin
        next_valid = 1'b1;                  // still waiting for ready
      end else begin
        if (limit_taken) begin
          limit_taken = 1'b0;
          void'(pending_limits.pop_front());
          in_gap = quiet ? 0 : pick_gap();
        end
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_limits.size() != 0) begin
          next_valid  = 1'b1;
          in_if.limit <= pending_limits[0];
        end
      end
    end
    in_if.valid <= next_valid;
  end

  // Result sink: random back-pressure, none in quiet stretches.
  always @(negedge clk) begin : result_sink
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 30) out_stall = pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // Monitors at the rising edge
  // --------------------------------------------------------------------------

  // Limit transfer: predict the whole run under the current method.
  always @(posedge clk) begin : limit_monitor
    int nres;
    int ops;
    if (rst_n && in_if.valid && in_if.ready) begin
      nres = list_primes(in_if.limit, method_shadow, ops);
      limit_taken = 1'b1;
      // generous bound: each modulo, each candidate with its root steps,
      // each result under the longest stall, plus the sender's longest gap
      cycle_allow += longint'(ops) * (VALUE_BITS + 4)
                   + longint'(int'(in_if.limit) + 2) * (2 * VALUE_BITS + 8)
                   + longint'(nres) * (MAX_GAP + 4) + MAX_GAP + 200;
    end
    // flip between idling and quiet stretches now and then
    if ($urandom_range(0, 299) == 0) quiet = !quiet;
  end

  // Result transfer: compare with the oldest prediction, field by field.
  always @(posedge clk) begin : result_monitor
    lister_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_items.size() == 0) begin
        $error("unexpected result: prime_value %0d is_count %0b mod_count %0d last %0b",
               out_if.prime_value, out_if.is_count, out_if.mod_count, out_if.last);
        error_count++;
      end else begin
        want = expected_items.pop_front();
        if (out_if.prime_value !== want.prime_value) begin
          $error("prime_value: expected %0d, got %0d", want.prime_value,
                 out_if.prime_value);
          error_count++;
        end
        if (out_if.is_count !== want.is_count) begin
          $error("is_count: expected %0b, got %0b", want.is_count, out_if.is_count);
          error_count++;
        end
        if (out_if.mod_count !== want.mod_count) begin
          $error("mod_count: expected %0d, got %0d", want.mod_count,
                 out_if.mod_count);
          error_count++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_if.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog; the allowance scales with the work actually handed over.
  initial begin
    cycle_count = 0;
    cycle_allow = 0;
    limit_taken = 1'b0;
    quiet       = 1'b0;
    in_gap      = 0;
    out_stall   = 0;
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > 4 * cycle_allow + 100000) begin
      $display("FAIL trial_division_prime_lister_top");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
rtl/tdpl_pkg.sv
rtl/tdpl_if.sv
rtl/trial_division_prime_lister_top.sv
rtl/tdpl_checker.sv
dv/tb_trial_division_prime_lister_top.sv
